// File: src/qrsd_pkg.sv
`default_nettype none
package qrsd_pkg;

  localparam int WINDOW_MAX_DEF = 128;
  localparam int FIFO_DEPTH = 4;
  localparam int RATE_W = 11;
  localparam logic [RATE_W-1:0] RATE_RESET = 11'd250;

  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] THR_FLOOR = 40'd256;
  localparam logic signed [10:0] DC_GAIN = 11'sd655;
  localparam logic signed [14:0] LP_GAIN = 15'sd13107;
  localparam logic [3:0] WIN_NUM = 4'd15;
  // floor(v/100) == (v*5243)>>19 for every v below 30706
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [9:0] BPM_SCALE = 10'd600;
  localparam logic [15:0] QRS_DEFAULT_MS = 16'd100;
  localparam logic [15:0] MAX16 = 16'hFFFF;

  typedef struct packed {
    logic signed [25:0] filtered;
    logic [39:0]        integrated;
  } front_word_t;

  typedef struct packed {
    logic        valid;
    front_word_t word;
  } fifo_head_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DC, F_DCU, F_LP, F_LPU, F_SQ, F_WIN, F_DIV, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_EVAL, B_SEED, B_WMUL, B_WSTART, B_WWAIT, B_RR, B_RWAIT,
    B_BWAIT, B_UPD, B_THR, B_FINISH, B_OUT
  } back_state_t;

  function automatic logic [39:0] make_threshold(input logic [39:0] noise,
                                                 input logic [39:0] sig);
    logic signed [41:0] diff;
    logic signed [41:0] t;
    begin
      diff = $signed({2'b00, sig}) - $signed({2'b00, noise});
      t = $signed({2'b00, noise}) + (diff >>> 2);
      if (t < $signed({2'b00, THR_FLOOR})) begin
        make_threshold = THR_FLOOR;
      end else if (t > $signed({2'b00, MAX40})) begin
        make_threshold = MAX40;
      end else begin
        make_threshold = t[39:0];
      end
    end
  endfunction

  // (p + 7*level) / 8
  function automatic logic [39:0] level_update(input logic [39:0] p,
                                               input logic [39:0] level);
    logic [43:0] s;
    begin
      s = {4'b0, p} + {1'b0, level, 3'b000} - {4'b0, level};
      level_update = s[42:3];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/qrsd_if.sv
`default_nettype none
interface qrsd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface qrsd_result_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] filtered;
  logic [39:0]        integrated;
  logic [39:0]        threshold;
  logic               r_peak;
  logic [31:0]        beat_index;
  logic [15:0]        qrs_ms;
  logic [15:0]        rr_ms;
  logic [19:0]        bpm_tenths;
  modport source (output valid, output filtered, output integrated, output threshold,
                  output r_peak, output beat_index, output qrs_ms, output rr_ms,
                  output bpm_tenths, input ready);
  modport sink (input valid, input filtered, input integrated, input threshold,
                input r_peak, input beat_index, input qrs_ms, input rr_ms,
                input bpm_tenths, output ready);
endinterface
`default_nettype wire

// File: src/qrsd_ram.sv
`default_nettype none
module qrsd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/qrsd_div.sv
`default_nettype none
module qrsd_div #(
  parameter int NW = 52,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        den_q <= den;
        rem   <= '0;
        cnt   <= CW'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, den_q}) begin
          rem <= DW'(trial - {1'b0, den_q});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/qrsd_fifo.sv
`default_nettype none
module qrsd_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire qrsd_pkg::front_word_t push_word,
  output logic                       full,
  input  wire logic                  pop,
  output qrsd_pkg::fifo_head_t       head
);
  localparam int D  = qrsd_pkg::FIFO_DEPTH;
  localparam int AW = (D > 1) ? $clog2(D) : 1;

  qrsd_pkg::front_word_t mem [D];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(D));
  assign head = '{valid: (count != '0), word: mem[rp]};

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(D - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(D - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: src/qrsd_front.sv
`default_nettype none
module qrsd_front #(
  parameter int WINDOW_MAX = qrsd_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [qrsd_pkg::RATE_W-1:0] rate,
  qrsd_sample_if.sink                      sample_ch,
  output logic                             push,
  output qrsd_pkg::front_word_t            push_word,
  input  wire logic                        full
);
  localparam int WW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TW = 40 + WW;

  qrsd_pkg::front_state_t state, state_next;

  logic signed [23:0] x;
  logic signed [31:0] dc;
  logic signed [31:0] lp;
  logic signed [31:0] prev;
  logic signed [32:0] hp;
  logic signed [43:0] prod_dc;
  logic signed [48:0] prod_lp;
  logic [26:0]        mag;
  logic [53:0]        sq_prod;
  logic [PW-1:0]      pos;
  logic               wrapped;
  logic [TW-1:0]      total;

  logic signed [32:0] d_dc;
  logic signed [31:0] dc_new;
  logic signed [33:0] d_lp;
  logic signed [31:0] lp_new;
  logic signed [32:0] slope;
  logic [45:0]        sq_wide;
  logic [39:0]        sq;
  logic [39:0]        old;
  logic [39:0]        rdata;
  logic [TW-1:0]      total_next;
  logic [14:0]        rate15;
  logic [27:0]        recip;
  logic [8:0]         win_raw;
  logic [WW-1:0]      win;
  logic               last_pos;
  logic               div_done;
  logic [TW-1:0]      div_q;

  // window length floor(0.15*rate), clamped to 1..WINDOW_MAX
  always_comb begin
    rate15  = 15'(rate) * 15'(qrsd_pkg::WIN_NUM);
    recip   = 28'(rate15) * 28'(qrsd_pkg::RECIP_100);
    win_raw = 9'(recip >> qrsd_pkg::RECIP_SHIFT);
    if (win_raw == '0) begin
      win = WW'(1);
    end else if (int'(win_raw) > WINDOW_MAX) begin
      win = WW'(WINDOW_MAX);
    end else begin
      win = WW'(win_raw);
    end
  end

  always_comb begin
    d_dc     = $signed({{9{x[23]}}, x}) - $signed({dc[31], dc});
    dc_new   = dc + 32'(prod_dc >>> 16);
    d_lp     = $signed({hp[32], hp}) - $signed({{2{lp[31]}}, lp});
    lp_new   = lp + 32'(prod_lp >>> 16);
    slope    = $signed({lp_new[31], lp_new}) - $signed({prev[31], prev});
    sq_wide  = sq_prod[53:8];
    sq       = (|sq_wide[45:40]) ? qrsd_pkg::MAX40 : sq_wide[39:0];
    old      = wrapped ? rdata : '0;
    total_next = total - TW'(old) + TW'(sq);
    last_pos = ((WW+1)'(pos) + 1'b1) >= (WW+1)'(win);
  end

  assign sample_ch.ready = (state == qrsd_pkg::F_IDLE);
  assign push            = (state == qrsd_pkg::F_PUSH) && !full;

  always_comb begin
    state_next = state;
    case (state)
      qrsd_pkg::F_IDLE: if (sample_ch.valid) state_next = qrsd_pkg::F_DC;
      qrsd_pkg::F_DC:   state_next = qrsd_pkg::F_DCU;
      qrsd_pkg::F_DCU:  state_next = qrsd_pkg::F_LP;
      qrsd_pkg::F_LP:   state_next = qrsd_pkg::F_LPU;
      qrsd_pkg::F_LPU:  state_next = qrsd_pkg::F_SQ;
      qrsd_pkg::F_SQ:   state_next = qrsd_pkg::F_WIN;
      qrsd_pkg::F_WIN:  state_next = qrsd_pkg::F_DIV;
      qrsd_pkg::F_DIV:  if (div_done) state_next = qrsd_pkg::F_PUSH;
      qrsd_pkg::F_PUSH: if (!full) state_next = qrsd_pkg::F_IDLE;
      default:          state_next = qrsd_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= qrsd_pkg::F_IDLE;
      dc      <= '0;
      lp      <= '0;
      prev    <= '0;
      pos     <= '0;
      wrapped <= 1'b0;
      total   <= '0;
    end else begin
      state <= state_next;
      case (state)
        qrsd_pkg::F_IDLE: if (sample_ch.valid) x <= {sample_ch.sample, 8'h00};
        qrsd_pkg::F_DC:   prod_dc <= d_dc * qrsd_pkg::DC_GAIN;
        qrsd_pkg::F_DCU: begin
          dc <= dc_new;
          hp <= $signed({{9{x[23]}}, x}) - $signed({dc_new[31], dc_new});
        end
        qrsd_pkg::F_LP:   prod_lp <= d_lp * qrsd_pkg::LP_GAIN;
        qrsd_pkg::F_LPU: begin
          lp   <= lp_new;
          prev <= lp_new;
          mag  <= slope[32] ? 27'(-slope) : 27'(slope);
        end
        qrsd_pkg::F_SQ:   sq_prod <= 54'(mag) * 54'(mag);
        qrsd_pkg::F_WIN: begin
          total <= total_next;
          if (last_pos) begin
            pos     <= '0;
            wrapped <= 1'b1;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        qrsd_pkg::F_DIV: begin
          if (div_done) begin
            push_word.filtered   <= lp[25:0];
            push_word.integrated <= (|div_q[TW-1:40]) ? qrsd_pkg::MAX40 : div_q[39:0];
          end
        end
        default: ;
      endcase
    end
  end

  qrsd_ram #(.WIDTH(40), .DEPTH(WINDOW_MAX)) u_win_ram (
    .clk   (clk),
    .we    (state == qrsd_pkg::F_WIN),
    .waddr (pos),
    .wdata (sq),
    .raddr (pos),
    .rdata (rdata)
  );

  qrsd_div #(.NW(TW), .DW(WW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == qrsd_pkg::F_WIN),
    .num   (total_next),
    .den   (win),
    .done  (div_done),
    .quo   (div_q)
  );
endmodule
`default_nettype wire

// File: src/qrsd_back.sv
`default_nettype none
module qrsd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [qrsd_pkg::RATE_W-1:0] rate,
  input  wire qrsd_pkg::fifo_head_t        head,
  output logic                             pop,
  qrsd_result_if.source                    result_ch
);
  qrsd_pkg::back_state_t state, state_next;

  logic        warmed;
  logic [51:0] wt;
  logic [39:0] whigh;
  logic [31:0] count;
  logic [39:0] noise;
  logic [39:0] sig;
  logic [39:0] thr;
  logic        above_half;
  logic [31:0] half_start;
  logic [31:0] last_w;
  logic        have_peak;
  logic [31:0] last_peak;
  logic [39:0] d1;
  logic [39:0] d2;

  qrsd_pkg::front_word_t cur;
  logic        r_peak;
  logic [31:0] r_idx;
  logic [15:0] wms;
  logic [15:0] rrms;
  logic [19:0] bpm;
  logic [31:0] rr;
  logic [41:0] wprod;
  logic [41:0] rrprod;
  logic [20:0] bprod;

  logic [10:0] rdiv;
  logic [51:0] wt_sum;
  logic [39:0] half;
  logic        is_peak;
  logic [31:0] peak_idx;
  logic        outside;
  logic        div_start;
  logic [51:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [51:0] div_q;
  logic [15:0] q16;

  always_comb begin
    rdiv     = (rate == '0) ? 11'd1 : rate;
    wt_sum   = wt + 52'(cur.integrated);
    half     = thr >> 1;
    is_peak  = (d1 > d2) && (d1 >= cur.integrated);
    peak_idx = count - 1'b1;
    outside  = !have_peak || ((peak_idx - last_peak) > 32'(rate >> 2));
    q16      = (|div_q[51:16]) ? qrsd_pkg::MAX16 : div_q[15:0];
  end

  // divider operands by step
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 32'(rdiv);
    case (state)
      qrsd_pkg::B_EVAL: begin
        div_start = !warmed && (count >= 32'(rate));
        div_num   = wt_sum;
      end
      qrsd_pkg::B_WSTART: begin
        div_start = wprod > 42'(rdiv);
        div_num   = 52'(wprod);
      end
      qrsd_pkg::B_RR: begin
        div_start = have_peak;
        div_num   = 52'(rrprod);
      end
      qrsd_pkg::B_RWAIT: begin
        div_start = div_done && (rrprod > 42'(rdiv));
        div_num   = 52'(bprod);
        div_den   = rr;
      end
      default: ;
    endcase
  end

  assign pop = (state == qrsd_pkg::B_IDLE) && head.valid;

  always_comb begin
    state_next = state;
    case (state)
      qrsd_pkg::B_IDLE:   if (head.valid) state_next = qrsd_pkg::B_EVAL;
      qrsd_pkg::B_EVAL: begin
        if (!warmed) begin
          state_next = (count >= 32'(rate)) ? qrsd_pkg::B_SEED : qrsd_pkg::B_FINISH;
        end else if (is_peak) begin
          state_next = (d1 > thr && outside) ? qrsd_pkg::B_WMUL : qrsd_pkg::B_THR;
        end else begin
          state_next = qrsd_pkg::B_FINISH;
        end
      end
      qrsd_pkg::B_SEED:   if (div_done) state_next = qrsd_pkg::B_THR;
      qrsd_pkg::B_WMUL:   state_next = qrsd_pkg::B_WSTART;
      qrsd_pkg::B_WSTART: state_next = div_start ? qrsd_pkg::B_WWAIT : qrsd_pkg::B_RR;
      qrsd_pkg::B_WWAIT:  if (div_done) state_next = qrsd_pkg::B_RR;
      qrsd_pkg::B_RR:     state_next = have_peak ? qrsd_pkg::B_RWAIT : qrsd_pkg::B_UPD;
      qrsd_pkg::B_RWAIT: begin
        if (div_done) begin
          state_next = div_start ? qrsd_pkg::B_BWAIT : qrsd_pkg::B_UPD;
        end
      end
      qrsd_pkg::B_BWAIT:  if (div_done) state_next = qrsd_pkg::B_UPD;
      qrsd_pkg::B_UPD:    state_next = qrsd_pkg::B_THR;
      qrsd_pkg::B_THR:    state_next = qrsd_pkg::B_FINISH;
      qrsd_pkg::B_FINISH: state_next = qrsd_pkg::B_OUT;
      qrsd_pkg::B_OUT: begin
        if (!result_ch.valid || result_ch.ready) state_next = qrsd_pkg::B_IDLE;
      end
      default:            state_next = qrsd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= qrsd_pkg::B_IDLE;
      warmed          <= 1'b0;
      wt              <= '0;
      whigh           <= '0;
      count           <= '0;
      noise           <= '0;
      sig             <= '0;
      thr             <= qrsd_pkg::THR_FLOOR;
      above_half      <= 1'b0;
      half_start      <= '0;
      last_w          <= '0;
      have_peak       <= 1'b0;
      last_peak       <= '0;
      d1              <= '0;
      d2              <= '0;
      result_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_ch.valid && result_ch.ready && state != qrsd_pkg::B_OUT) begin
        result_ch.valid <= 1'b0;
      end
      case (state)
        qrsd_pkg::B_IDLE: begin
          if (head.valid) begin
            cur    <= head.word;
            r_peak <= 1'b0;
            r_idx  <= '0;
            wms    <= '0;
            rrms   <= '0;
            bpm    <= '0;
          end
        end
        qrsd_pkg::B_EVAL: begin
          if (!warmed) begin
            wt <= wt_sum;
            if (cur.integrated > whigh) whigh <= cur.integrated;
          end else begin
            // half-threshold crossing tracks QRS width
            if (!above_half && cur.integrated > half) begin
              above_half <= 1'b1;
              half_start <= count;
            end else if (above_half && cur.integrated <= half) begin
              last_w     <= count - half_start;
              above_half <= 1'b0;
            end
            if (is_peak) begin
              if (d1 > thr && outside) begin
                r_peak <= 1'b1;
                r_idx  <= peak_idx;
                rr     <= peak_idx - last_peak;
              end else begin
                noise <= qrsd_pkg::level_update(d1, noise);
              end
            end
          end
        end
        qrsd_pkg::B_SEED: begin
          if (div_done) begin
            noise  <= (|div_q[51:40]) ? qrsd_pkg::MAX40 : div_q[39:0];
            sig    <= whigh >> 1;
            warmed <= 1'b1;
          end
        end
        qrsd_pkg::B_WMUL: begin
          wprod  <= 42'(last_w) * 42'(qrsd_pkg::MS_PER_S);
          rrprod <= 42'(rr) * 42'(qrsd_pkg::MS_PER_S);
          bprod  <= 21'(rdiv) * 21'(qrsd_pkg::BPM_SCALE);
        end
        qrsd_pkg::B_WSTART: if (!div_start) wms <= qrsd_pkg::QRS_DEFAULT_MS;
        qrsd_pkg::B_WWAIT:  if (div_done) wms <= q16;
        qrsd_pkg::B_RWAIT:  if (div_done) rrms <= q16;
        qrsd_pkg::B_BWAIT:  if (div_done) bpm <= div_q[19:0];
        qrsd_pkg::B_UPD: begin
          last_peak <= r_idx;
          have_peak <= 1'b1;
          sig       <= qrsd_pkg::level_update(d1, sig);
        end
        qrsd_pkg::B_THR:    thr <= qrsd_pkg::make_threshold(noise, sig);
        qrsd_pkg::B_FINISH: begin
          d2    <= d1;
          d1    <= cur.integrated;
          count <= count + 1'b1;
        end
        qrsd_pkg::B_OUT: begin
          if (!result_ch.valid || result_ch.ready) begin
            result_ch.valid      <= 1'b1;
            result_ch.filtered   <= cur.filtered;
            result_ch.integrated <= cur.integrated;
            result_ch.threshold  <= thr;
            result_ch.r_peak     <= r_peak;
            result_ch.beat_index <= r_idx;
            result_ch.qrs_ms     <= wms;
            result_ch.rr_ms      <= rrms;
            result_ch.bpm_tenths <= bpm;
          end
        end
        default: ;
      endcase
    end
  end

  qrsd_div #(.NW(52), .DW(32)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );
endmodule
`default_nettype wire

// File: src/qrs_peak_detector.sv
// QRS peak detector: band-pass, slope energy, moving-window mean, adaptive peak picking.
// The front end takes a new sample only after the last one has been pushed, and its
// 48-step window-mean divide sets its pace; a reported peak adds up to three 52-step
// divides in the back end, and the item that ends warm-up adds one. The queue absorbs
// the longer back-end items, and output stalls hold the back end.
// Reset (rst, synchronous, active high) clears all state and sets the rate to 250 Hz;
// a rate write clears all detector state as well and keeps the new rate.
`default_nettype none
module qrs_peak_detector #(
  parameter int WINDOW_MAX = qrsd_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [qrsd_pkg::RATE_W-1:0] cfg_wdata,
  qrsd_sample_if.sink                      sample_ch,
  qrsd_result_if.source                    result_ch
);
  logic [qrsd_pkg::RATE_W-1:0] rate;
  logic                        clear;
  logic                        push;
  logic                        full;
  logic                        pop;
  qrsd_pkg::front_word_t       push_word;
  qrsd_pkg::fifo_head_t        head;

  // Hold the sample rate; a write restarts the detector from scratch.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= qrsd_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate <= cfg_wdata;
    end
  end

  assign clear = rst || cfg_we;

  // Front end: filters, squares the slope and averages over the window.
  qrsd_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk       (clk),
    .rst       (clear),
    .rate      (rate),
    .sample_ch (sample_ch),
    .push      (push),
    .push_word (push_word),
    .full      (full)
  );

  // Short queue lets the front keep filtering while the back divides.
  qrsd_fifo u_fifo (
    .clk       (clk),
    .rst       (clear),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  // Back end: warm-up seeding, thresholding, peak report and timing math.
  qrsd_back u_back (
    .clk       (clk),
    .rst       (clear),
    .rate      (rate),
    .head      (head),
    .pop       (pop),
    .result_ch (result_ch)
  );
endmodule
`default_nettype wire

// File: src/qrsd_checker.sv
`default_nettype none
module qrsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [39:0] threshold,
  input wire logic        r_peak,
  input wire logic [31:0] beat_index,
  input wire logic [15:0] qrs_ms,
  input wire logic [15:0] rr_ms,
  input wire logic [19:0] bpm_tenths
);
  a_rst_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !r_peak |-> beat_index == '0 && qrs_ms == '0 &&
                            rr_ms == '0 && bpm_tenths == '0)
    else $error("peak fields set without peak");

  a_thr_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> threshold >= 40'd256)
    else $error("threshold below floor");

  a_bpm_rr: assert property (@(posedge clk) disable iff (rst)
    res_valid && bpm_tenths != '0 |-> rr_ms != '0)
    else $error("rate without interval");
endmodule

bind qrs_peak_detector qrsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result_ch.valid),
  .res_ready  (result_ch.ready),
  .threshold  (result_ch.threshold),
  .r_peak     (result_ch.r_peak),
  .beat_index (result_ch.beat_index),
  .qrs_ms     (result_ch.qrs_ms),
  .rr_ms      (result_ch.rr_ms),
  .bpm_tenths (result_ch.bpm_tenths)
);
`default_nettype wire

// File: tb/qrs_peak_detector_tb_if.sv
`timescale 1ns / 100ps
`default_nettype none
package qrsd_tb_pkg;
  typedef struct packed {
    logic signed [25:0] filtered;
    logic [39:0]        integrated;
    logic [39:0]        threshold;
    logic               r_peak;
    logic [31:0]        beat_index;
    logic [15:0]        qrs_ms;
    logic [15:0]        rr_ms;
    logic [19:0]        bpm_tenths;
  } beat_word_t;
endpackage
`default_nettype wire

// File: tb/qrs_peak_detector_test.sv
`timescale 1ns / 100ps
`default_nettype none
module qrs_peak_detector_test;

  localparam int WMAX = 128;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [39:0] TOP40 = 40'hFF_FFFF_FFFF;
  // A zero sample right after reset leaves every stage at zero, threshold at its floor.
  localparam qrsd_tb_pkg::beat_word_t ZERO_AFTER_RESET =
    '{26'sd0, 40'd0, 40'd256, 1'b0, 32'd0, 16'd0, 16'd0, 20'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [10:0] cfg_wdata = 11'd0;

  always #5 clk = ~clk;

  qrsd_sample_if sample_ch ();
  qrsd_result_if result_ch ();

  qrs_peak_detector uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .sample_ch(sample_ch.sink), .result_ch(result_ch.source)
  );

  // Shadow of the detector state.
  logic [10:0] rate;
  longint dc_lvl, lp_lvl, lp_prev;
  logic [39:0] win_buf [WMAX];
  logic [63:0] win_sum;
  int unsigned win_pos;
  bit warm;
  logic [63:0] warm_sum;
  logic [39:0] warm_top;
  logic [31:0] n_seen;
  logic [39:0] noise_lvl, sig_lvl, thr_lvl;
  bit over_half;
  logic [31:0] half_at, width_cnt;
  bit peak_seen;
  logic [31:0] peak_at;
  logic [39:0] integ_d1, integ_d2;

  qrsd_tb_pkg::beat_word_t beat_q[$];
  int fails = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [39:0] thr_of(logic [39:0] n, logic [39:0] sg);
    longint t;
    t = longint'(n) + fdiv(longint'(sg) - longint'(n), 2);
    if (t < 256) t = 256;
    if (t > longint'(TOP40)) t = longint'(TOP40);
    return t[39:0];
  endfunction

  task automatic clear_shadow();
    dc_lvl = 0; lp_lvl = 0; lp_prev = 0;
    for (int i = 0; i < WMAX; i++) win_buf[i] = '0;
    win_sum = 0; win_pos = 0; warm = 0; warm_sum = 0; warm_top = 0;
    n_seen = 0; noise_lvl = 0; sig_lvl = 0; thr_lvl = 40'd256;
    over_half = 0; half_at = 0; width_cnt = 0; peak_seen = 0; peak_at = 0;
    integ_d1 = 0; integ_d2 = 0;
  endtask

  // Advance the shadow detector by one sample and return the expected word.
  function automatic qrsd_tb_pkg::beat_word_t detect_beat(logic signed [15:0] smp);
    qrsd_tb_pkg::beat_word_t w;
    longint x, slope;
    logic [63:0] mag, sq, integ, wms, rr, rms;
    int unsigned win, rdiv, refr;
    logic [31:0] pk_idx;
    logic [39:0] pk, half;
    bit outside;
    w = '0;
    win = (32'(rate) * 15) / 100;
    if (win < 1) win = 1;
    if (win > WMAX) win = WMAX;
    rdiv = (rate == 0) ? 1 : rate;
    x = longint'(smp) * 256;
    dc_lvl += fdiv(655 * (x - dc_lvl), 16);
    lp_lvl += fdiv(13107 * ((x - dc_lvl) - lp_lvl), 16);
    slope = lp_lvl - lp_prev;
    lp_prev = lp_lvl;
    mag = (slope < 0) ? -slope : slope;
    sq = (mag * mag) >> 8;
    if (sq > TOP40) sq = TOP40;
    if (win_pos >= win) win_pos = 0;
    win_sum = win_sum - win_buf[win_pos] + sq;
    win_buf[win_pos] = sq[39:0];
    win_pos = (win_pos + 1 >= win) ? 0 : win_pos + 1;
    integ = win_sum / win;
    if (integ > TOP40) integ = TOP40;
    w.filtered = lp_lvl[25:0];
    w.integrated = integ[39:0];
    if (!warm) begin
      warm_sum += integ;
      if (integ[39:0] > warm_top) warm_top = integ[39:0];
      if (n_seen >= 32'(rate)) begin
        noise_lvl = (warm_sum / rdiv > TOP40) ? TOP40 : 40'(warm_sum / rdiv);
        sig_lvl = warm_top >> 1;
        thr_lvl = thr_of(noise_lvl, sig_lvl);
        warm = 1;
      end
    end else begin
      half = thr_lvl >> 1;
      if (!over_half && integ > half) begin
        over_half = 1; half_at = n_seen;
      end else if (over_half && integ <= half) begin
        width_cnt = n_seen - half_at; over_half = 0;
      end
      if (integ_d1 > integ_d2 && integ_d1 >= integ) begin
        pk_idx = n_seen - 1;
        pk = integ_d1;
        refr = rate / 4;
        outside = !peak_seen || (pk_idx - peak_at) > refr;
        if (pk > thr_lvl && outside) begin
          w.r_peak = 1;
          w.beat_index = pk_idx;
          if (64'(width_cnt) * 1000 > rdiv) begin
            wms = 64'(width_cnt) * 1000 / rdiv;
            w.qrs_ms = (wms > 65535) ? 16'hFFFF : wms[15:0];
          end else begin
            w.qrs_ms = 16'd100;
          end
          if (peak_seen) begin
            rr = 64'(32'(pk_idx - peak_at));
            rms = rr * 1000 / rdiv;
            w.rr_ms = (rms > 65535) ? 16'hFFFF : rms[15:0];
            if (rr * 1000 > rdiv) w.bpm_tenths = 20'((64'(rdiv) * 600) / rr);
          end
          peak_at = pk_idx; peak_seen = 1;
          sig_lvl = 40'(({4'b0, pk} + 44'd7 * sig_lvl) >> 3);
        end else begin
          noise_lvl = 40'(({4'b0, pk} + 44'd7 * noise_lvl) >> 3);
        end
        thr_lvl = thr_of(noise_lvl, sig_lvl);
      end
    end
    integ_d2 = integ_d1;
    integ_d1 = integ[39:0];
    n_seen++;
    w.threshold = thr_lvl;
    return w;
  endfunction

  // Sender: hold the word until accepted, then idle for a random gap.
  // A typed row queues its written-in word; the shadow still advances.
  task automatic send_sample(logic signed [15:0] smp, bit typed = 1'b0,
                             qrsd_tb_pkg::beat_word_t want = '0);
    int gap;
    qrsd_tb_pkg::beat_word_t pred;
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= smp;
    do @(posedge clk); while (!sample_ch.ready);
    pred = detect_beat(smp);
    beat_q.push_back(typed ? want : pred);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4));
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_rate(logic [10:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate = r;
    clear_shadow();
  endtask

  // Synthetic ECG: flat baseline with sharp spikes every period samples.
  task automatic send_beats(int count, int period, int amp);
    int v;
    for (int i = 0; i < count; i++) begin
      v = $urandom_range(0, 400) - 200;
      if (i % period < 3) v += amp * (i % period == 1 ? 2 : 1);
      if ($urandom_range(0, 49) == 0) v = $urandom_range(0, 65535) - 32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_sample(16'(v));
    end
  endtask

  // Receiver: stall at random, compare each word with the oldest prediction.
  always @(posedge clk) begin
    qrsd_tb_pkg::beat_word_t got, want;
    if (result_ch.valid && result_ch.ready) begin
      got = '{result_ch.filtered, result_ch.integrated, result_ch.threshold,
              result_ch.r_peak, result_ch.beat_index, result_ch.qrs_ms,
              result_ch.rr_ms, result_ch.bpm_tenths};
      if (beat_q.size() == 0) begin
        $error("result word with nothing pending");
        fails++;
      end else begin
        want = beat_q.pop_front();
        if (got.filtered !== want.filtered) begin
          $error("filtered exp %0d got %0d", want.filtered, got.filtered); fails++;
        end
        if (got.integrated !== want.integrated) begin
          $error("integrated exp %0d got %0d", want.integrated, got.integrated); fails++;
        end
        if (got.threshold !== want.threshold) begin
          $error("threshold exp %0d got %0d", want.threshold, got.threshold); fails++;
        end
        if (got.r_peak !== want.r_peak) begin
          $error("r_peak exp %0d got %0d", want.r_peak, got.r_peak); fails++;
        end
        if (got.beat_index !== want.beat_index) begin
          $error("beat_index exp %0d got %0d", want.beat_index, got.beat_index);
          fails++;
        end
        if (got.qrs_ms !== want.qrs_ms) begin
          $error("qrs_ms exp %0d got %0d", want.qrs_ms, got.qrs_ms);
          fails++;
        end
        if (got.rr_ms !== want.rr_ms) begin
          $error("rr_ms exp %0d got %0d", want.rr_ms, got.rr_ms); fails++;
        end
        if (got.bpm_tenths !== want.bpm_tenths) begin
          $error("bpm_tenths exp %0d got %0d", want.bpm_tenths, got.bpm_tenths); fails++;
        end
      end
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      // hold off the output for a long stretch now and then
      result_ch.ready <= 1'b0;
      stall_left <= $urandom_range(20, 200);
    end else if ($urandom_range(0, 9) < 7) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(0, 29) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed samples: zero after reset, field extremes, every bit of the sample,
  // sign changes.
  logic signed [15:0] edge_rows [21] = '{
    16'sd0,
    16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, 16'sh5555, -16'sh5556,
    16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sd0, 16'sd0, 16'sh0100, 16'sh00FF,
    16'sh7FFF, -16'sh8000, 16'sd1234, -16'sd1234
  };

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    rate = 11'd250;
    clear_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first row after reset carries its expected word typed in.
    for (int i = 0; i < $size(edge_rows); i++) begin
      send_sample(edge_rows[i], i == 0, ZERO_AFTER_RESET);
    end

    // Low rate: warm-up is short and beats come fast.
    set_rate(11'd50);
    send_beats(200, 40, 30000);
    // Rate zero: window one, no refractory interval.
    set_rate(11'd0);
    send_beats(150, 5, 20000);
    // Rate one and top rate: bpm and width at the edges, widest window.
    set_rate(11'd1);
    send_beats(100, 7, 25000);
    set_rate(11'h7FF);
    send_beats(200, 60, 32000);
    // Pause the sender until every word has come back.
    drain();
    set_rate(11'd250);
    send_beats(600, 60 + $urandom_range(0, 180), 10000 + $urandom_range(0, 20000));
    set_rate(11'($urandom_range(50, 200)));
    send_beats(330, $urandom_range(20, 150), $urandom_range(2000, 32000));

    drain();
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: qrs_peak_detector.f
src/qrsd_pkg.sv
src/qrsd_if.sv
src/qrsd_ram.sv
src/qrsd_div.sv
src/qrsd_fifo.sv
src/qrsd_front.sv
src/qrsd_back.sv
src/qrs_peak_detector.sv
src/qrsd_checker.sv
tb/qrs_peak_detector_tb_if.sv
tb/qrs_peak_detector_test.sv
